/* hw/rtl/lpht_pkg.sv */
`default_nettype none

package lpht_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 64;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = IDX_W;
    localparam bit IS_POW2    = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    // Field widths
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int SS_W     = 2;

    // Home-slot remainder: quotient estimate from floor(2^32 / TABLE_SIZE),
    // low by at most one, then one conditional subtract
    localparam int                 RECIP_W    = 32;
    localparam logic [RECIP_W-1:0] HASH_RECIP =
        RECIP_W'((64'd1 << RECIP_W) / 64'(TABLE_SIZE));
    localparam int                 HASH_STEPS = 2;
    localparam int                 HCNT_W     = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Slot status codes
    localparam logic [SS_W-1:0] SS_EMPTY = 2'd0;
    localparam logic [SS_W-1:0] SS_LIVE  = 2'd1;
    localparam logic [SS_W-1:0] SS_GONE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value_out;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    // One table row as stored in the RAM
    typedef struct packed {
        logic [SS_W-1:0]    st;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] payload;
    } slot_t;

    // Microprogram
    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UA_WAIT  = 3'd0;
    localparam upc_t UA_HASH  = 3'd1;
    localparam upc_t UA_START = 3'd2;
    localparam upc_t UA_READ  = 3'd3;
    localparam upc_t UA_TEST  = 3'd4;
    localparam upc_t UA_HIT   = 3'd5;  // must be UA_TEST + OC_HIT
    localparam upc_t UA_END   = 3'd6;  // must be UA_TEST + OC_END

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NOT_ACCEPT,
        C_HASH_BUSY,
        C_OP_BAD,
        C_DISPATCH
    } cond_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_HIT,
        RES_END
    } res_t;

    // Probe outcome, added to the dispatch base
    typedef enum logic [1:0] {
        OC_CONT,
        OC_HIT,
        OC_END
    } outcome_t;

    typedef struct packed {
        logic  ready;     // take a request transaction
        logic  hash_go;   // one remainder step
        logic  pos_load;  // start the probe at the home slot
        logic  rd_first;  // read the slot at pos
        logic  probe;     // test slot, advance and read next on continue
        logic  wait_out;  // hold the step while the output register is full
        res_t  emit;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic     accept;
        logic     hash_busy;
        logic     op_bad;
        logic     out_busy;
        outcome_t outcome;
    } dp_stat_t;

    // Control store
    function automatic ctrl_t urom(input upc_t a);
        ctrl_t w;
        w = '{ready: 1'b0, hash_go: 1'b0, pos_load: 1'b0, rd_first: 1'b0,
              probe: 1'b0, wait_out: 1'b0, emit: RES_NONE, cond: C_ALWAYS,
              target: UA_WAIT};
        unique case (a)
            UA_WAIT:
            begin
                w.ready  = 1'b1;
                w.cond   = C_NOT_ACCEPT;
                w.target = UA_WAIT;
            end
            UA_HASH:
            begin
                w.hash_go = 1'b1;
                w.cond    = C_HASH_BUSY;
                w.target  = UA_HASH;
            end
            UA_START:
            begin
                w.pos_load = 1'b1;
                w.cond     = C_OP_BAD;
                w.target   = UA_END;
            end
            UA_READ:
            begin
                w.rd_first = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = UA_TEST;
            end
            UA_TEST:
            begin
                w.probe  = 1'b1;
                w.cond   = C_DISPATCH;
                w.target = UA_TEST;
            end
            UA_HIT:
            begin
                w.wait_out = 1'b1;
                w.emit     = RES_HIT;
                w.cond     = C_ALWAYS;
                w.target   = UA_WAIT;
            end
            UA_END:
            begin
                w.wait_out = 1'b1;
                w.emit     = RES_END;
                w.cond     = C_ALWAYS;
                w.target   = UA_WAIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = UA_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpht_ram.sv */
`default_nettype none

// Simple dual-port RAM, registered read
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpht_useq.sv */
`default_nettype none

// Microsequencer: step counter, control store, conditional and dispatch jumps
module lpht_useq
    import lpht_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_stat_t st,
    output ctrl_t         cw
);

    upc_t upc_reg;
    upc_t upc_next;
    logic hold;
    logic take;

    assign cw   = urom(upc_reg);
    assign hold = cw.wait_out & st.out_busy;

    // Branch condition
    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:     take = 1'b1;
            C_NOT_ACCEPT: take = ~st.accept;
            C_HASH_BUSY:  take = st.hash_busy;
            C_OP_BAD:     take = st.op_bad;
            C_DISPATCH:   take = 1'b1;
            default:      take = 1'b1;
        endcase
    end

    // Next step
    always_comb
    begin
        priority if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (cw.cond == C_DISPATCH)
        begin
            upc_next = cw.target + UPC_W'(st.outcome);
        end
        else if (take)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpht_dpath.sv */
`default_nettype none

// Datapath: request registers, home-slot remainder, probe pointer,
// slot RAM with per-slot valid bits, result register
module lpht_dpath
    import lpht_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctrl_t cw,
    output dp_stat_t   st,
    input  wire logic  req_valid,
    input  wire req_t  req,
    input  wire logic  rsp_ready,
    output logic       rsp_valid,
    output rsp_t       rsp
);

    // Request registers
    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    // Home-slot remainder: quotient step, then correction step; a power-of-two size takes the low key bits
    logic [IDX_W-1:0]         rem_reg;
    logic [IDX_W-1:0]         rem_next;
    logic [HCNT_W-1:0]        hcnt_reg;
    logic [KEY_W-1:0]         quot_reg;
    logic [KEY_W+RECIP_W-1:0] hprod;
    logic [KEY_W-1:0]         quot_n;
    logic [KEY_W-1:0]         rem_raw;

    // Probe pointer
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] pos_inc;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Slot store
    logic [TABLE_SIZE-1:0] valid_reg;
    logic                  valid_q_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [$bits(slot_t)-1:0] ram_rdata;
    slot_t                 rd_slot;
    slot_t                 wr_slot;
    logic                  wr_en;
    logic [SS_W-1:0]       slot_st;

    // Result
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  emit_en;
    logic [IDX_W+SLOT_W-1:0] pos_ext;

    logic     accept;
    logic     out_busy;
    logic     is_ins;
    logic     cont;
    outcome_t outcome;

    assign accept   = cw.ready & req_valid;
    assign out_busy = rsp_valid_reg & ~rsp_ready;
    assign emit_en  = (cw.emit != RES_NONE) & ~out_busy;
    assign is_ins   = (op_reg == OP_INSERT);

    assign st.accept    = accept;
    assign st.hash_busy = (hcnt_reg != '0);
    assign st.op_bad    = (op_reg != OP_SEARCH) && (op_reg != OP_INSERT)
                          && (op_reg != OP_DELETE);
    assign st.out_busy  = out_busy;
    assign st.outcome   = outcome;

    // Remainder: key minus quotient times table size, at most one subtract left
    assign hprod    = (KEY_W+RECIP_W)'(key_reg) * (KEY_W+RECIP_W)'(HASH_RECIP);
    assign quot_n   = quot_reg * KEY_W'(TABLE_SIZE);
    assign rem_raw  = key_reg - quot_n;
    assign rem_next = (rem_raw >= KEY_W'(TABLE_SIZE))
                      ? IDX_W'(rem_raw - KEY_W'(TABLE_SIZE))
                      : IDX_W'(rem_raw);

    // Slot seen by the current probe
    assign rd_slot = slot_t'(ram_rdata);
    assign slot_st = valid_q_reg ? rd_slot.st : SS_EMPTY;

    // Probe outcome
    always_comb
    begin
        priority if (is_ins ? (slot_st != SS_LIVE)
                            : (slot_st == SS_LIVE && rd_slot.key == key_reg))
        begin
            outcome = OC_HIT;
        end
        else if (!is_ins && slot_st == SS_EMPTY)
        begin
            outcome = OC_END;
        end
        else if (cnt_reg == CNT_W'(TABLE_SIZE - 1))
        begin
            outcome = OC_END;
        end
        else
        begin
            outcome = OC_CONT;
        end
    end

    assign cont    = cw.probe & (outcome == OC_CONT);
    assign pos_inc = (pos_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + IDX_W'(1);
    assign rd_en   = cw.rd_first | cont;
    assign rd_addr = cw.probe ? pos_inc : pos_reg;

    always_comb
    begin
        priority if (cw.pos_load)
        begin
            pos_next = rem_reg;
            cnt_next = '0;
        end
        else if (cont)
        begin
            pos_next = pos_inc;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
            cnt_next = cnt_reg;
        end
    end

    // Write-back: insert fills the slot, delete leaves a marker
    assign wr_en = emit_en && (cw.emit == RES_HIT) && (is_ins || op_reg == OP_DELETE);
    always_comb
    begin
        if (is_ins)
        begin
            wr_slot = '{st: SS_LIVE, key: key_reg, payload: value_reg};
        end
        else
        begin
            wr_slot = '{st: SS_GONE, key: rd_slot.key, payload: rd_slot.payload};
        end
    end

    lpht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (pos_reg),
        .wdata (wr_slot),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Result transaction contents
    assign pos_ext = {{SLOT_W{1'b0}}, pos_reg};
    always_comb
    begin
        if (cw.emit == RES_HIT)
        begin
            rsp_next.status    = ST_OK;
            rsp_next.value_out = is_ins ? '0 : rd_slot.payload;
            rsp_next.slot      = pos_ext[SLOT_W-1:0];
        end
        else
        begin
            rsp_next.status    = is_ins ? ST_FULL : ST_MISS;
            rsp_next.value_out = '0;
            rsp_next.slot      = '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            hcnt_reg      <= '0;
        end
        else
        begin
            if (wr_en && is_ins)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end

            if (emit_en)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                hcnt_reg <= IS_POW2 ? '0 : HCNT_W'(HASH_STEPS);
            end
            else if (cw.hash_go && hcnt_reg != '0)
            begin
                hcnt_reg <= hcnt_reg - HCNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.op;
            key_reg    <= req.key;
            value_reg  <= req.value;
            rem_reg    <= IS_POW2 ? req.key[IDX_W-1:0] : '0;
        end
        else if (cw.hash_go && hcnt_reg == HCNT_W'(HASH_STEPS))
        begin
            quot_reg   <= hprod[KEY_W+RECIP_W-1:RECIP_W];
        end
        else if (cw.hash_go && hcnt_reg == HCNT_W'(1))
        begin
            rem_reg    <= rem_next;
        end

        pos_reg <= pos_next;
        cnt_reg <= cnt_next;

        if (rd_en)
        begin
            valid_q_reg <= valid_reg[rd_addr];
        end

        if (emit_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/linear_probe_hash_table.sv */
`default_nettype none

// Channel   Handshake              Payload     Direction
// req       req_valid/req_ready    req_t       in  (op, key, value)
// rsp       rsp_valid/rsp_ready    rsp_t       out (status, value_out, slot)
//
// One request in flight. A request probes 1 to TABLE_SIZE slots, one slot
// RAM read per probe; an unused op code skips the probe. A table size that
// is not a power of two adds the quotient and correction steps of the
// home-slot remainder. Reset clears all slots to empty at once through
// per-slot valid bits. A stalled rsp holds the sequencer only at the final
// step; the next request is taken while a result still waits.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctrl_t    cw;
    dp_stat_t st;

    assign req_ready = cw.ready;

    lpht_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cw    (cw)
    );

    lpht_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .st        (st),
        .req_valid (req_valid),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb
    import lpht_pkg::*;
();

    // op code with no operation behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Shadow copy of the slot table; predicts each reply and checks it
    class probe_table_shadow;
        logic [SS_W-1:0]    slot_state   [TABLE_SIZE];
        logic [KEY_W-1:0]   slot_key     [TABLE_SIZE];
        logic [VALUE_W-1:0] slot_payload [TABLE_SIZE];
        rsp_t               expected_replies [$];
        int                 mismatches;
        int                 replies_seen;

        function new();
            foreach (slot_state[i])
            begin
                slot_state[i]   = SS_EMPTY;
                slot_key[i]     = '0;
                slot_payload[i] = '0;
            end
            mismatches   = 0;
            replies_seen = 0;
        endfunction

        // first live slot holding k along the probe path, -1 if none
        function int find_live(logic [KEY_W-1:0] k);
            int pos;
            pos = int'(k) % TABLE_SIZE;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                if (slot_state[pos] == SS_EMPTY)
                    return -1;
                if (slot_state[pos] == SS_LIVE && slot_key[pos] == k)
                    return pos;
                pos = (pos + 1) % TABLE_SIZE;
            end
            return -1;
        endfunction

        // first empty or deleted slot from home, -1 when the table is full
        function int find_free(logic [KEY_W-1:0] k);
            int pos;
            pos = int'(k) % TABLE_SIZE;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                if (slot_state[pos] != SS_LIVE)
                    return pos;
                pos = (pos + 1) % TABLE_SIZE;
            end
            return -1;
        endfunction

        // apply one request to the shadow table and return its reply
        function rsp_t apply_request(req_t r);
            rsp_t o;
            int   idx;
            o.status    = ST_MISS;
            o.value_out = '0;
            o.slot      = '0;
            case (r.op)
                OP_SEARCH:
                begin
                    idx = find_live(r.key);
                    if (idx >= 0)
                    begin
                        o.status    = ST_OK;
                        o.value_out = slot_payload[idx];
                        o.slot      = SLOT_W'(idx);
                    end
                end
                OP_INSERT:
                begin
                    idx = find_free(r.key);
                    if (idx >= 0)
                    begin
                        slot_state[idx]   = SS_LIVE;
                        slot_key[idx]     = r.key;
                        slot_payload[idx] = r.value;
                        o.status          = ST_OK;
                        o.slot            = SLOT_W'(idx);
                    end
                    else
                        o.status = ST_FULL;
                end
                OP_DELETE:
                begin
                    idx = find_live(r.key);
                    if (idx >= 0)
                    begin
                        o.status        = ST_OK;
                        o.value_out     = slot_payload[idx];
                        o.slot          = SLOT_W'(idx);
                        slot_state[idx] = SS_GONE;
                    end
                end
                default:
                    ;
            endcase
            return o;
        endfunction

        function void note_request(req_t r);
            expected_replies.push_back(apply_request(r));
        endfunction

        function void check_reply(rsp_t got);
            rsp_t want;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: reply %0d unexpected: status %0d value_out %h slot %0d",
                             replies_seen, got.status, got.value_out, got.slot);
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.value_out !== want.value_out ||
                got.slot !== want.slot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: reply %0d exp/got: status %0d/%0d value %h/%h slot %0d/%0d",
                             replies_seen, want.status, got.status, want.value_out,
                             got.value_out, want.slot, got.slot);
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    probe_table_shadow shadow = new();
    logic [KEY_W-1:0]  used_keys [$];
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_cycles    = 0;

    linear_probe_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Reply side: check accepted transactions, stall at random or for a long hold
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            shadow.check_reply(rsp);
        if (hold_cycles > 0)
        begin
            rsp_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // keys either fully random or bunched near the ends of the table
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [9:0] hi;
        logic [5:0] lo;
        if ($urandom_range(1) == 1)
            return KEY_W'($urandom());
        hi = 10'($urandom_range(1023));
        lo = ($urandom_range(1) == 1) ? 6'($urandom_range(7)) : 6'($urandom_range(63, 56));
        return {hi, lo};
    endfunction

    // offer one request transaction and wait for it to be taken
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.note_request(r);
        if (r.op == OP_INSERT)
            used_keys.push_back(r.key);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VALUE_W-1:0] v);
        req_t r;
        r.op    = op;
        r.key   = k;
        r.value = v;
        send_request(r);
    endtask

    function automatic logic [KEY_W-1:0] known_key();
        return used_keys[$urandom_range(used_keys.size() - 1)];
    endfunction

    // one random request; most lookups and removals aim at inserted keys
    task automatic send_random(input int ins_pct, input int del_pct);
        req_t r;
        int   pick;
        pick    = $urandom_range(99);
        r.value = $urandom();
        r.key   = fresh_key();
        if (pick < 2)
            r.op = OP_UNUSED;
        else if (pick < 2 + ins_pct)
        begin
            r.op = OP_INSERT;
            if (used_keys.size() > 0 && $urandom_range(99) < 20)
                r.key = known_key();
        end
        else
        begin
            r.op = (pick < 2 + ins_pct + del_pct) ? OP_DELETE : OP_SEARCH;
            if (used_keys.size() > 0 && $urandom_range(99) < 75)
                r.key = known_key();
        end
        send_request(r);
    endtask

    // hold the request side idle until every reply is back
    task automatic drain_replies();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.outstanding() != 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table misses, extremes, collisions, wrap, duplicates, deleted markers
        send_op(OP_SEARCH, 16'h0000, 32'h0000_0000);
        send_op(OP_DELETE, 16'h0005, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 16'h0000, 32'h0000_0000);
        send_op(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 16'h0040, 32'hA5A5_A5A5);
        send_op(OP_INSERT, 16'h007F, 32'h1234_5678);
        send_op(OP_SEARCH, 16'h007F, 32'h0000_0000);
        send_op(OP_SEARCH, 16'hFFFF, 32'h0000_0000);
        send_op(OP_INSERT, 16'h0000, 32'h0000_0001);
        send_op(OP_SEARCH, 16'h0000, 32'h0000_0000);
        send_op(OP_DELETE, 16'h0000, 32'h0000_0000);
        send_op(OP_SEARCH, 16'h0000, 32'h0000_0000);
        send_op(OP_SEARCH, 16'h0040, 32'h0000_0000);
        send_op(OP_INSERT, 16'h0080, 32'h5A5A_5A5A);
        send_op(OP_UNUSED, 16'h0040, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 16'h0040, 32'h0000_0000);
        send_op(OP_SEARCH, 16'h0040, 32'h0000_0000);
        send_op(OP_INSERT, 16'h8000, 32'h8000_0000);
        send_op(OP_INSERT, 16'hAAAA, 32'h5555_5555);
        send_op(OP_INSERT, 16'h5555, 32'hAAAA_AAAA);
        send_op(OP_SEARCH, 16'h5555, 32'h0000_0000);
        send_op(OP_DELETE, 16'hFFFF, 32'h0000_0000);
        send_op(OP_SEARCH, 16'h007F, 32'h0000_0000);
        drain_replies();

        // no idling, balanced mix
        repeat (95) send_random(50, 20);
        drain_replies();

        // sender idles, insert heavy so the table fills and reports full
        send_idle_pct = 65;
        repeat (95) send_random(83, 5);
        drain_replies();

        // receiver stalls, with a long hold so requests back up; delete heavy
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        hold_cycles   <= 400;
        repeat (95) send_random(15, 55);
        drain_replies();

        // both sides idle
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        repeat (95) send_random(40, 30);
        drain_replies();

        repeat (100) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
